FILE: rtl/dzq_pkg.sv
package dzq_pkg;

    // fixed field widths
    localparam int LEVEL_W   = 6;
    localparam int SIZE_W    = 10;
    localparam int BAND_W    = 6;
    localparam int COUNT_W   = 6;
    localparam int SCALE_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;
    localparam int MDATA_W   = 8;

    // upper bound on middle-area tests per sample
    localparam int MAX_AREAS = 63;

    // signed width for the sample and boundary compares; holds samples up to 16 bits and sz*(i+1)
    localparam int ARITH_W = 19;
    // accumulated boundary sz*i, i below 64
    localparam int BASE_W  = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0]  area_size;
        logic [BAND_W-1:0]  dead_band;
        logic [COUNT_W-1:0] area_count;
        logic [SCALE_W-1:0] full_scale;
    } t_cfg;

    typedef struct packed {
        logic load;     // latch sample, restart scan at area 1
        logic step;     // advance to next area boundary
    } t_scan_ctrl;

    typedef struct packed {
        logic               bot_hit;
        logic               mid_hit;
        logic               mid_more;
        logic               top_hit;
        logic [LEVEL_W-1:0] idx;
    } t_scan_stat;

endpackage

FILE: rtl/dzq_scan.sv
module dzq_scan #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                    i_clk,
    input  dzq_pkg::t_cfg           i_cfg,
    input  dzq_pkg::t_scan_ctrl     i_ctrl,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    output dzq_pkg::t_scan_stat     o_stat
);
    import dzq_pkg::*;

    logic [SAMPLE_BITS-1:0] r_smp;
    logic [BASE_W-1:0]      r_base;
    logic [LEVEL_W-1:0]     r_idx;

    logic signed [ARITH_W-1:0] s_x;
    logic signed [ARITH_W-1:0] sz_x;
    logic signed [ARITH_W-1:0] db_x;
    logic signed [ARITH_W-1:0] fs_x;
    logic signed [ARITH_W-1:0] base_x;

    // boundary accumulator: base = area_size * idx, no multiplier
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_smp  <= i_sample;
            r_base <= BASE_W'(i_cfg.area_size);
            r_idx  <= LEVEL_W'(1);
        end else if (i_ctrl.step) begin
            r_base <= r_base + BASE_W'(i_cfg.area_size);
            r_idx  <= r_idx + LEVEL_W'(1);
        end
    end

    assign s_x    = $signed(ARITH_W'(r_smp));
    assign sz_x   = $signed(ARITH_W'(i_cfg.area_size));
    assign db_x   = $signed(ARITH_W'(i_cfg.dead_band));
    assign fs_x   = $signed(ARITH_W'(i_cfg.full_scale));
    assign base_x = $signed(ARITH_W'(r_base));

    always_comb begin
        o_stat.bot_hit  = s_x < (sz_x - db_x);
        o_stat.mid_hit  = (s_x > (base_x + db_x)) && (s_x < (base_x + sz_x - db_x));
        o_stat.mid_more = (r_idx < i_cfg.area_count) &&
                          ({2'b00, r_idx} < 8'(MAX_AREAS));
        o_stat.top_hit  = s_x > (fs_x - db_x);
        o_stat.idx      = r_idx;
    end

endmodule

FILE: rtl/deadzone_hysteresis_quantizer_unit.sv
// channel | dir | tdata fields (lsb up)              | notes
// s_axis  | in  | sample[SAMPLE_BITS-1:0], zero pad  | one raw converter reading
// m_axis  | out | level[5:0], changed[6], zero[7]    | one result per sample
// cfg     | in  | we / idx[1:0] / data[10:0]         | area_size, dead_band, area_count, full_scale
//
// a sample runs the bottom test, the middle areas and the top test in turn, stopping at the
// first one that hits, before its result is handed off; the next sample is accepted only
// once the scan is back in idle; the scan uses a single compare unit that walks the area
// boundaries one per cycle
// synchronous active-low reset: config returns to 18/5/55/1024, last level to 0
// the output register holds a result while the next sample is accepted and scanned;
// the scan only stalls in its final state while that register is still occupied
module deadzone_hysteresis_quantizer_unit #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // slave stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // sample, zero pad
    // master stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [dzq_pkg::MDATA_W-1:0]            o_m_axis_tdata,  // level, changed, zero
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [dzq_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [dzq_pkg::CFG_DAT_W-1:0]          i_cfg_data
);
    import dzq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BOT  = 5'b00010,
        S_MID  = 5'b00100,
        S_TOP  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_cfg               r_cfg;
    logic [LEVEL_W-1:0] r_last;
    logic [LEVEL_W-1:0] r_res, n_res;
    logic               r_ov;
    logic [LEVEL_W-1:0] r_olevel;
    logic               r_ochg;

    t_scan_ctrl scan_ctrl;
    t_scan_stat scan_stat;

    logic s_fire;
    logic m_fire;
    logic fin_fire;

    // no transaction is taken while reset is held
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign m_fire          = r_ov && i_m_axis_tready;
    // final state hands off once the output register is free or being drained
    assign fin_fire        = (r_state == S_FIN) && (!r_ov || i_m_axis_tready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_size  <= SIZE_W'(18);
            r_cfg.dead_band  <= BAND_W'(5);
            r_cfg.area_count <= COUNT_W'(55);
            r_cfg.full_scale <= SCALE_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AREA_SIZE:  r_cfg.area_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_DEAD_BAND:  r_cfg.dead_band  <= i_cfg_data[BAND_W-1:0];
                CFG_AREA_COUNT: r_cfg.area_count <= i_cfg_data[COUNT_W-1:0];
                CFG_FULL_SCALE: r_cfg.full_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    dzq_scan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_ctrl   (scan_ctrl),
        .i_sample (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_stat   (scan_stat)
    );

    // sequencer: bottom test, walk middle areas, top test, hand off
    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        scan_ctrl.load = 1'b0;
        scan_ctrl.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    scan_ctrl.load = 1'b1;
                    n_state        = S_BOT;
                end
            end
            S_BOT: begin
                if (scan_stat.bot_hit) begin
                    n_res   = '0;
                    n_state = S_FIN;
                end else begin
                    n_state = S_MID;
                end
            end
            S_MID: begin
                if (!scan_stat.mid_more) begin
                    n_state = S_TOP;
                end else if (scan_stat.mid_hit) begin
                    n_res   = scan_stat.idx;
                    n_state = S_FIN;
                end else begin
                    scan_ctrl.step = 1'b1;
                end
            end
            S_TOP: begin
                // top test hit gives area_count; if no rule matched, hold the previous level
                n_res   = scan_stat.top_hit ? r_cfg.area_count : r_last;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_fire) begin
                r_last <= r_res;
                r_ov   <= 1'b1;
            end else if (m_fire) begin
                r_ov   <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (fin_fire) begin
            r_olevel <= r_res;
            r_ochg   <= (r_res != r_last);
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {1'b0, r_ochg, r_olevel};

    // a transaction on the input always starts the scan with the bottom test
    a_start_bot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state == S_BOT))
        else $error("scan did not start at bottom test");

    // area index never wraps while walking the middle areas
    a_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID) |-> (scan_stat.idx != '0))
        else $error("middle area index wrapped");

    // changed flag matches the level against the one it replaced
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_fire |=> (r_ochg == (r_olevel != $past(r_last))))
        else $error("changed flag inconsistent with level");

    // result register only loaded when it is free or draining this cycle
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_fire && r_ov) |-> i_m_axis_tready)
        else $error("pending result overwritten");

endmodule

FILE: test/tb_deadzone_hysteresis_quantizer_unit.sv
module tb_deadzone_hysteresis_quantizer_unit;
    import dzq_pkg::*;

    localparam int SAMPLE_W       = 10;
    localparam int S_TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 82;
    // limit covers the slowest sample plus the long receiver hold
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int END_WAIT       = 80;
    localparam int SETTLE_CYCLES  = 4;

    // one quantizer result as it leaves the master stream
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               changed;
    } t_level_result;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_s_axis_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]    i_s_axis_tdata   = '0;     // sample, zero pad
    logic                    i_m_axis_tready  = 1'b0;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx        = CFG_AREA_SIZE;
    logic [CFG_DAT_W-1:0]    i_cfg_data       = '0;
    logic                    o_s_axis_tready;
    logic                    o_m_axis_tvalid;
    logic [MDATA_W-1:0]      o_m_axis_tdata;            // level[5:0], changed[6], zero[7]

    deadzone_hysteresis_quantizer_unit #(
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // shadow copy of the block's registers and its held level
    t_cfg                cfg_shadow;
    logic [LEVEL_W-1:0]  held_level;

    logic [SAMPLE_W-1:0] sample_queue[$];      // samples waiting for the driver
    t_level_result       expected_levels[$];   // predicted results, oldest first

    int   samples_queued     = 0;
    int   samples_taken      = 0;
    int   errors             = 0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   hold_left          = 0;
    int   quiet_cycles       = 0;
    logic hold_req           = 1'b0;   // raised once by the stimulus
    logic hold_done          = 1'b0;   // owned by the monitor

    // level for one sample under the current shadow config and held level
    // rules tried in order: bottom area, middle areas, top area, else hold
    function automatic logic [LEVEL_W-1:0] quantize_level(input logic [SAMPLE_W-1:0] s);
        int sz;
        int db;
        int v;
        sz = int'(cfg_shadow.area_size);
        db = int'(cfg_shadow.dead_band);
        v  = int'(s);
        // signed compare: a wide dead band pushes this threshold negative
        if (v < sz - db)
            return '0;
        for (int i = 1; i < int'(cfg_shadow.area_count) && i < MAX_AREAS; i++) begin
            if (v > sz * i + db && v < sz * (i + 1) - db)
                return LEVEL_W'(i);
        end
        if (v > int'(cfg_shadow.full_scale) - db)
            return cfg_shadow.area_count;
        return held_level;
    endfunction

    // random sample, mostly aimed at area boundaries and their dead bands
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        int db;
        int area;
        db = int'(cfg_shadow.dead_band);
        case ($urandom_range(0, 7))
            0, 1: begin
                v = int'($urandom_range(0, 1023));
            end
            2: begin
                v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
            end
            3: begin
                v = int'(cfg_shadow.full_scale) - db + int'($urandom_range(0, 4)) - 2;
            end
            default: begin
                area = int'($urandom_range(0, int'(cfg_shadow.area_count) + 1));
                v = int'(cfg_shadow.area_size) * area
                    + int'($urandom_range(0, 2 * db + 6)) - db - 3;
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return SAMPLE_W'(v);
    endfunction

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    // wait until every queued sample is taken and every result has come back
    task automatic drain();
        while (samples_taken != samples_queued || expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four registers back to back, only while the block is idle
    task automatic write_config(input t_cfg c);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_AREA_SIZE;
        i_cfg_data <= CFG_DAT_W'(c.area_size);
        cfg_shadow.area_size = c.area_size;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEAD_BAND;
        i_cfg_data <= CFG_DAT_W'(c.dead_band);
        cfg_shadow.dead_band = c.dead_band;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AREA_COUNT;
        i_cfg_data <= CFG_DAT_W'(c.area_count);
        cfg_shadow.area_count = c.area_count;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FULL_SCALE;
        i_cfg_data <= CFG_DAT_W'(c.full_scale);
        cfg_shadow.full_scale = c.full_scale;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver: offers queued samples, predicts each accepted transaction
    always @(posedge i_clk) begin : driver
        logic                 next_valid;
        logic [S_TDATA_W-1:0] next_data;
        t_level_result        r;
        next_valid = i_s_axis_tvalid;
        next_data  = i_s_axis_tdata;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r.level   = quantize_level(i_s_axis_tdata[SAMPLE_W-1:0]);
                r.changed = (r.level != held_level);
                held_level = r.level;
                expected_levels.push_back(r);
                samples_taken++;
                next_valid = 1'b0;
            end
            // a pending offer is held; a new one may be delayed by a random gap
            if (!next_valid && sample_queue.size() != 0 &&
                int'($urandom_range(0, 99)) >= sender_idle_pct) begin
                next_valid = 1'b1;
                next_data  = S_TDATA_W'(sample_queue.pop_front());
            end
        end
        i_s_axis_tvalid <= next_valid;
        i_s_axis_tdata  <= next_data;
    end

    // monitor: checks each result transaction and drives backpressure
    always @(posedge i_clk) begin : monitor
        t_level_result want;
        logic          next_ready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_levels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got level %0d changed %0b",
                         $time, o_m_axis_tdata[LEVEL_W-1:0], o_m_axis_tdata[LEVEL_W]);
            end else begin
                want = expected_levels.pop_front();
                if (o_m_axis_tdata[LEVEL_W-1:0] !== want.level) begin
                    errors++;
                    $display("%0t: level mismatch, expected %0d, got %0d",
                             $time, want.level, o_m_axis_tdata[LEVEL_W-1:0]);
                end
                if (o_m_axis_tdata[LEVEL_W] !== want.changed) begin
                    errors++;
                    $display("%0t: changed mismatch, expected %0b, got %0b",
                             $time, want.changed, o_m_axis_tdata[LEVEL_W]);
                end
            end
        end
        // one long hold so the block fills up and stalls its input
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else begin
            next_ready = int'($urandom_range(0, 99)) >= receiver_stall_pct;
        end
        i_m_axis_tready <= next_ready;
    end

    // watchdog: ends the run after too many cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus: directed samples at reset values, then one random phase per setting
    initial begin : stimulus
        // area_size, dead_band, area_count, full_scale
        int   cfg_table[N_PHASES][4] = '{
            '{18,   5,  55, 1024},   // reset values written explicitly
            '{1,    0,  63, 1024},   // narrowest areas, no dead band, most areas
            '{1023, 63, 1,  1024},   // widest area, widest band, single area
            '{16,   3,  63, 1023},
            '{0,    5,  10, 1000},   // zero area size: only the top rule can hit
            '{20,   0,  0,  512},    // zero area count: top rule gives level 0
            '{4,    10, 40, 300},    // dead band wider than the bottom threshold
            '{30,   63, 20, 2047},   // full scale beyond any sample
            '{1023, 0,  63, 1},      // full scale at its low end
            '{50,   7,  20, 1024},
            '{17,   2,  60, 1024},
            '{18,   5,  55, 1024}
        };
        int   directed[25] = '{0, 1023, 12, 13, 14, 22, 23, 24, 30, 31, 40, 41, 1018,
                               1019, 1020, 990, 989, 500, 12, 18, 1023, 24, 12, 512, 5};
        t_cfg c;

        cfg_shadow.area_size  = SIZE_W'(18);
        cfg_shadow.dead_band  = BAND_W'(5);
        cfg_shadow.area_count = COUNT_W'(55);
        cfg_shadow.full_scale = SCALE_W'(1024);
        held_level = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset config: extremes, both sides of bands
        foreach (directed[k])
            queue_sample(SAMPLE_W'(directed[k]));
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            c.area_size  = SIZE_W'(cfg_table[p][0]);
            c.dead_band  = BAND_W'(cfg_table[p][1]);
            c.area_count = COUNT_W'(cfg_table[p][2]);
            c.full_scale = SCALE_W'(cfg_table[p][3]);
            write_config(c);
            // rotate through: no idling, sender gaps, receiver stalls, both light
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            if (p == 4)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_sample(pick_sample());
            // sender pauses here until every expected result has come
            drain();
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            errors++;
            $display("%0t: missing results, expected %0d more, got 0",
                     $time, expected_levels.size());
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dzq_pkg.sv
rtl/dzq_scan.sv
rtl/deadzone_hysteresis_quantizer_unit.sv
test/tb_deadzone_hysteresis_quantizer_unit.sv
